// File: hw/rtl/spf_pkg.sv
// Shared types and constants for the scan-line span filler.
package spf_pkg;
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_SCAN  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam int unsigned ResultLimit = 8;
endpackage

// File: hw/rtl/spf_sort_cell.sv
// One cell of the insertion sorter chain: holds one crossing, shifts right on insert.
module spf_sort_cell #(
  parameter int unsigned VW = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_i,
  input  logic                 ins_i,
  input  logic signed [VW-1:0] new_i,
  input  logic signed [VW-1:0] left_val_i,
  input  logic                 left_full_i,
  input  logic                 left_gt_i,
  output logic signed [VW-1:0] val_o,
  output logic                 full_o,
  output logic                 gt_o
);
  logic signed [VW-1:0] val_q;
  logic                 full_q;

  assign val_o  = val_q;
  assign full_o = full_q;
  assign gt_o   = full_q && (val_q > new_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (clr_i) begin
      full_q <= 1'b0;
    end else if (ins_i && left_full_i) begin
      full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      if (left_gt_i && left_full_i) begin
        val_q <= left_val_i;
      end else if (left_full_i && (gt_o || !full_q)) begin
        val_q <= new_i;
      end
    end
  end
endmodule

// File: hw/rtl/spf_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
module spf_divider #(
  parameter int unsigned NW = 18,
  parameter int unsigned DW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q;
  logic [DW:0]   rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [DW:0]   trial;

  assign trial  = {rem_q[DW-1:0], quo_q[NW-1]};
  assign quo_o  = quo_q;
  assign done_o = busy_q && (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end
endmodule

// File: hw/rtl/scanline_polygon_span_fill.sv
// Top level of the scan-line polygon span filler.
//
// channel   direction  handshake          payload
// command   in         start / busy       command_i, x_a_i, y_a_i, x_b_i, y_b_i, scan_y_i
// result    out        result_valid_o     status_o, span_valid_o, span_y_o, span_x_start_o,
//                                         span_x_end_o, span_color_o, last_o
// config    in         fill_color_we_i    fill_color_i
//
// Clear answers the transfer with one result; add waits for the divider before its result.
// Scan reads, multiplies and inserts each edge into the sorter chain before its first
// result; it then shows one span per cycle.
// Reset empties the edge table and sets the fill colour to 15; no clearing pass.
// Results cannot be stalled; busy drops in the cycle that shows the last result.
module scanline_polygon_span_fill #(
  parameter int unsigned MAX_EDGES  = 16,
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command_i,
  input  logic [COORD_BITS-1:0] x_a_i,
  input  logic [COORD_BITS-1:0] y_a_i,
  input  logic [COORD_BITS-1:0] x_b_i,
  input  logic [COORD_BITS-1:0] y_b_i,
  input  logic [COORD_BITS-1:0] scan_y_i,
  input  logic                  fill_color_we_i,
  input  logic [3:0]            fill_color_i,
  output logic                  result_valid_o,
  output logic                  status_o,
  output logic                  span_valid_o,
  output logic [COORD_BITS-1:0] span_y_o,
  output logic [COORD_BITS-1:0] span_x_start_o,
  output logic [COORD_BITS-1:0] span_x_end_o,
  output logic [3:0]            span_color_o,
  output logic                  last_o
);
  localparam int unsigned AW  = $clog2(MAX_EDGES);
  localparam int unsigned NCW = $clog2(MAX_EDGES + 1);
  localparam int unsigned NW  = COORD_BITS + FRAC_BITS;
  localparam int unsigned SW  = NW + 1;
  localparam int unsigned VW  = COORD_BITS + NW + 3;
  localparam int unsigned EW  = 3 * COORD_BITS + SW;
  localparam int unsigned KW  = $clog2(spf_pkg::ResultLimit + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_WRITE, ST_RD, ST_MUL, ST_INS, ST_EMIT, ST_ONE
  } state_e;

  typedef struct packed {
    logic                  clr;
    logic                  ins;
  } sort_ctl_t;

  state_e state_q;
  logic [NCW-1:0] count_q;
  logic [NCW-1:0] idx_q;
  logic [3:0] color_q;
  logic [COORD_BITS-1:0] y_q, xt_q, yt_q, yb_q;
  logic neg_q, flat_q;
  logic [EW-1:0] mem_q [MAX_EDGES];
  logic [EW-1:0] rd_q;
  logic rd_ok_q, act_q;
  logic signed [VW-1:0] prod_q;
  logic [KW-1:0] k_q;
  logic [NCW-1:0] n_q;
  logic one_st_q;

  // divider
  logic div_start, div_done;
  logic [NW-1:0] div_quo;
  logic [COORD_BITS-1:0] adx, ady;
  logic [SW-1:0] slope;

  spf_divider #(.NW(NW), .DW(COORD_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i({adx, FRAC_BITS'(0)}), .den_i(ady),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic ya_top;
  logic [COORD_BITS-1:0] xt_n, yt_n, yb_n, xb_n;
  assign ya_top = y_a_i >= y_b_i;
  assign xt_n = ya_top ? x_a_i : x_b_i;
  assign yt_n = ya_top ? y_a_i : y_b_i;
  assign yb_n = ya_top ? y_b_i : y_a_i;
  assign xb_n = ya_top ? x_b_i : x_a_i;
  assign adx  = (xb_n >= xt_n) ? xb_n - xt_n : xt_n - xb_n;
  assign ady  = yt_n - yb_n;
  assign slope = flat_q ? '0 : (neg_q ? -{1'b0, div_quo} : {1'b0, div_quo});

  logic accept;
  assign accept = start && !busy;
  assign div_start = accept && (spf_pkg::cmd_e'(command_i) == spf_pkg::CMD_ADD)
                     && (count_q < NCW'(MAX_EDGES));

  // stored edge fields
  logic [COORD_BITS-1:0] e_xt, e_yt, e_yb;
  logic signed [SW-1:0] e_sl;
  assign {e_xt, e_yt, e_yb, e_sl} = rd_q;

  // sorter chain
  sort_ctl_t sctl;
  logic signed [VW-1:0] cv [MAX_EDGES];
  logic cf [MAX_EDGES];
  logic cg [MAX_EDGES];
  logic signed [VW-1:0] newv;
  assign newv = prod_q;

  for (genvar g = 0; g < MAX_EDGES; g++) begin : g_cell
    spf_sort_cell #(.VW(VW)) u_cell (
      .clk_i, .rst_ni, .clr_i(sctl.clr), .ins_i(sctl.ins), .new_i(newv),
      .left_val_i(g == 0 ? cv[0] : cv[(g == 0) ? 0 : g - 1]),
      .left_full_i(g == 0 ? 1'b1 : cf[(g == 0) ? 0 : g - 1]),
      .left_gt_i(g == 0 ? 1'b0 : cg[(g == 0) ? 0 : g - 1]),
      .val_o(cv[g]), .full_o(cf[g]), .gt_o(cg[g])
    );
  end

  // span output: pair k_q from a chain read
  logic [AW:0] li, ri;
  logic signed [VW-1:0] lv, rv, rc;
  logic signed [VW-1:0] fl, ce;
  logic [COORD_BITS-1:0] xs_c, xe_c;
  localparam logic signed [VW-1:0] MaxC = VW'((1 << COORD_BITS) - 1);
  assign li = (AW + 1)'({k_q, 1'b0});
  assign ri = li + 1'b1;
  assign lv = cv[li[AW-1:0]];
  assign rv = cv[ri[AW-1:0]];
  assign rc = rv + VW'((1 << FRAC_BITS) - 1);
  assign fl = lv >>> FRAC_BITS;
  assign ce = rc >>> FRAC_BITS;
  assign xs_c = fl < 0 ? '0 : (fl > MaxC ? MaxC[COORD_BITS-1:0] : fl[COORD_BITS-1:0]);
  assign xe_c = ce < 0 ? '0 : (ce > MaxC ? MaxC[COORD_BITS-1:0] : ce[COORD_BITS-1:0]);

  logic [NCW-1:0] half;
  assign half = n_q >> 1;

  always_comb begin
    sctl.clr = accept;
    sctl.ins = (state_q == ST_INS) && act_q;
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[idx_q[AW-1:0]];
    if (state_q == ST_WRITE) begin
      mem_q[count_q[AW-1:0]] <= {xt_q, yt_q, yb_q, slope};
    end
    prod_q <= VW'(signed'({1'b0, e_xt, FRAC_BITS'(0)}))
              + VW'(signed'({1'b0, y_q}) - signed'({1'b0, e_yt})) * VW'(e_sl);
    act_q <= rd_ok_q && (e_yb < y_q) && (y_q <= e_yt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      color_q <= 4'd15;
      idx_q <= '0;
      rd_ok_q <= 1'b0;
      n_q <= '0;
      k_q <= '0;
      y_q <= '0;
      xt_q <= '0; yt_q <= '0; yb_q <= '0;
      neg_q <= 1'b0; flat_q <= 1'b0;
      one_st_q <= 1'b0;
      result_valid_o <= 1'b0;
      status_o <= 1'b0; span_valid_o <= 1'b0; span_y_o <= '0;
      span_x_start_o <= '0; span_x_end_o <= '0; span_color_o <= '0; last_o <= 1'b0;
    end else begin
      if (fill_color_we_i) color_q <= fill_color_i;
      result_valid_o <= (state_q == ST_ONE) || (state_q == ST_EMIT);
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (spf_pkg::cmd_e'(command_i))
              spf_pkg::CMD_CLEAR: begin
                one_st_q <= 1'b0;
                count_q <= '0;
                state_q <= ST_ONE;
              end
              spf_pkg::CMD_ADD: begin
                if (count_q >= NCW'(MAX_EDGES)) begin
                  one_st_q <= 1'b1;
                  state_q <= ST_ONE;
                end else begin
                  one_st_q <= 1'b0;
                  xt_q <= xt_n; yt_q <= yt_n; yb_q <= yb_n;
                  flat_q <= (ady == '0);
                  neg_q <= (xb_n > xt_n);
                  state_q <= ST_DIV;
                end
              end
              spf_pkg::CMD_SCAN: begin
                y_q <= scan_y_i;
                idx_q <= '0;
                n_q <= '0;
                k_q <= '0;
                rd_ok_q <= 1'b0;
                state_q <= ST_RD;
              end
              default: begin
                one_st_q <= 1'b0;
                state_q <= ST_ONE;
              end
            endcase
          end
        end
        ST_DIV: if (div_done) state_q <= ST_WRITE;
        ST_WRITE: begin
          count_q <= count_q + 1'b1;
          state_q <= ST_ONE;
        end
        ST_RD: begin
          // memory read lands in rd_q next cycle
          rd_ok_q <= (idx_q < count_q);
          state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_INS;
        ST_INS: begin
          if (act_q) n_q <= n_q + 1'b1;
          if (idx_q + 1'b1 >= NCW'(MAX_EDGES)) begin
            state_q <= ST_EMIT;
            k_q <= '0;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_EMIT: begin
          if (half == '0) begin
            status_o <= 1'b0; span_valid_o <= 1'b0; span_y_o <= y_q;
            span_x_start_o <= '0; span_x_end_o <= '0; span_color_o <= '0;
            last_o <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            status_o <= 1'b0; span_valid_o <= 1'b1; span_y_o <= y_q;
            span_x_start_o <= xs_c; span_x_end_o <= xe_c; span_color_o <= color_q;
            if ((NCW'(k_q) + 1'b1 >= half) || (k_q + 1'b1 >= KW'(spf_pkg::ResultLimit))) begin
              last_o <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              last_o <= 1'b0;
              k_q <= k_q + 1'b1;
            end
          end
        end
        ST_ONE: begin
          status_o <= one_st_q; span_valid_o <= 1'b0; span_y_o <= '0;
          span_x_start_o <= '0; span_x_end_o <= '0; span_color_o <= '0;
          last_o <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/spf_checker.sv
// Port-level checks for the span filler, bound to the top level.
module spf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input logic span_valid_o,
  input logic status_o,
  input logic last_o
);
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("transfer not followed by busy");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> ##1 !result_valid_o) else $error("result after last");
  a_no_idle_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy) else $error("open result while idle");
  a_status_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o) |-> (!span_valid_o && last_o)) else $error("bad status");
endmodule

bind scanline_polygon_span_fill spf_checker u_spf_checker (
  .clk_i, .rst_ni, .start, .busy, .result_valid_o, .span_valid_o, .status_o, .last_o
);
